/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCX_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCX_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pcxrle_pkg.sv */
package pcxrle_pkg;

    localparam int TDATA_W = 72;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_HDR_OK  = 2'd1,
        KIND_HDR_ERR = 2'd2
    } kind_t;

    localparam logic [2:0] ERR_SIGNATURE = 3'd0;
    localparam logic [2:0] ERR_VERSION   = 3'd1;
    localparam logic [2:0] ERR_COMPRESS  = 3'd2;
    localparam logic [2:0] ERR_BPP       = 3'd3;
    localparam logic [2:0] ERR_RESERVED  = 3'd4;

    localparam logic [7:0] SIGNATURE   = 8'd10;
    localparam logic [7:0] VERSION_MAX = 8'd5;
    localparam logic [7:0] COMPRESS_RLE = 8'd1;
    localparam logic [1:0] RUN_MARK    = 2'b11;

    // header byte offsets
    localparam logic [6:0] POS_SIG    = 7'd0;
    localparam logic [6:0] POS_VER    = 7'd1;
    localparam logic [6:0] POS_COMP   = 7'd2;
    localparam logic [6:0] POS_BPP    = 7'd3;
    localparam logic [6:0] POS_XLO    = 7'd8;
    localparam logic [6:0] POS_XHI    = 7'd9;
    localparam logic [6:0] POS_YLO    = 7'd10;
    localparam logic [6:0] POS_YHI    = 7'd11;
    localparam logic [6:0] POS_RSV    = 7'd64;
    localparam logic [6:0] POS_PLANES = 7'd65;
    localparam logic [6:0] POS_LBLO   = 7'd66;
    localparam logic [6:0] POS_LBHI   = 7'd67;
    localparam logic [6:0] POS_LAST   = 7'd127;

    typedef struct packed {
        logic  emit;
        kind_t kind;
        logic  from_run;
        logic  hdr_step;
        logic  hdr_finish;
        logic  run_cnt_load;
        logic  run_val_load;
        logic  px_count;
    } dp_cmd_t;

    typedef struct packed {
        logic fail;
        logic pos_last;
        logic marker;
        logic cnt_zero;
        logic run_one;
        logic img_last;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/pcxrle_dp.sv */
`include "assert_macros.svh"

module pcxrle_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [7:0]                  byte_in,
    input  logic                        first,
    input  pcxrle_pkg::dp_cmd_t         cmd,
    output pcxrle_pkg::dp_status_t      status,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [pcxrle_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  eff_pos;
    logic [15:0] x_end_reg, y_end_reg, line_bytes_reg;
    logic [3:0]  bpp_reg;
    logic [7:0]  planes_reg;
    logic [32:0] prod_reg;
    logic [32:0] rem_reg;
    logic [5:0]  run_cnt_reg;
    logic [7:0]  run_val_reg;

    logic [16:0] x_p1, y_p1;
    logic [33:0] prod_full;

    logic        fail;
    logic [2:0]  err_code;

    logic        out_valid_reg;
    pcxrle_pkg::kind_t out_kind_reg;
    logic [7:0]  out_pixel_reg;
    logic [2:0]  out_err_reg;
    logic [15:0] out_x_reg, out_y_reg, out_lb_reg;
    logic [3:0]  out_bpp_reg;
    logic [7:0]  out_planes_reg;
    logic        out_done_reg;
    logic        out_last_reg;

    logic        img_last;
    logic        out_free;

    assign eff_pos  = first ? pcxrle_pkg::POS_SIG : pos_reg;
    assign img_last = (rem_reg == 33'd1);
    assign out_free = !out_valid_reg || m_tready;
    assign pos_next = eff_pos + 7'd1;

    // header checks on the byte at its position
    always_comb
    begin
        fail     = 1'b0;
        err_code = pcxrle_pkg::ERR_SIGNATURE;
        unique case (eff_pos)
            pcxrle_pkg::POS_SIG:
            begin
                fail     = (byte_in != pcxrle_pkg::SIGNATURE);
                err_code = pcxrle_pkg::ERR_SIGNATURE;
            end
            pcxrle_pkg::POS_VER:
            begin
                fail     = (byte_in > pcxrle_pkg::VERSION_MAX);
                err_code = pcxrle_pkg::ERR_VERSION;
            end
            pcxrle_pkg::POS_COMP:
            begin
                fail     = (byte_in != pcxrle_pkg::COMPRESS_RLE);
                err_code = pcxrle_pkg::ERR_COMPRESS;
            end
            pcxrle_pkg::POS_BPP:
            begin
                fail     = !(byte_in == 8'd1 || byte_in == 8'd2 ||
                             byte_in == 8'd4 || byte_in == 8'd8);
                err_code = pcxrle_pkg::ERR_BPP;
            end
            pcxrle_pkg::POS_RSV:
            begin
                fail     = (byte_in != 8'd0);
                err_code = pcxrle_pkg::ERR_RESERVED;
            end
            default:
            begin
                fail     = 1'b0;
                err_code = pcxrle_pkg::ERR_SIGNATURE;
            end
        endcase
    end

    assign status.fail     = fail;
    assign status.pos_last = (eff_pos == pcxrle_pkg::POS_LAST);
    assign status.marker   = (byte_in[7:6] == pcxrle_pkg::RUN_MARK);
    assign status.cnt_zero = (run_cnt_reg == 6'd0);
    assign status.run_one  = (run_cnt_reg == 6'd1);
    assign status.img_last = img_last;
    assign status.out_free = out_free;

    // pixel count limit, registered product, stable from byte 11 on
    assign x_p1      = {1'b0, x_end_reg} + 17'd1;
    assign y_p1      = {1'b0, y_end_reg} + 17'd1;
    assign prod_full = x_p1 * y_p1;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[32:0];
        if (cmd.hdr_step)
        begin
            unique case (eff_pos)
                pcxrle_pkg::POS_BPP:    bpp_reg <= byte_in[3:0];
                pcxrle_pkg::POS_XLO:    x_end_reg[7:0] <= byte_in;
                pcxrle_pkg::POS_XHI:    x_end_reg[15:8] <= byte_in;
                pcxrle_pkg::POS_YLO:    y_end_reg[7:0] <= byte_in;
                pcxrle_pkg::POS_YHI:    y_end_reg[15:8] <= byte_in;
                pcxrle_pkg::POS_PLANES: planes_reg <= byte_in;
                pcxrle_pkg::POS_LBLO:   line_bytes_reg[7:0] <= byte_in;
                pcxrle_pkg::POS_LBHI:   line_bytes_reg[15:8] <= byte_in;
                default:
                begin
                end
            endcase
        end
        if (cmd.run_val_load)
        begin
            run_val_reg <= byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            rem_reg     <= '0;
            run_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.hdr_finish)
            begin
                pos_reg <= '0;
                rem_reg <= prod_reg;
            end
            else if (cmd.hdr_step)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.px_count)
            begin
                rem_reg <= rem_reg - 33'd1;
            end
            if (cmd.run_cnt_load)
            begin
                run_cnt_reg <= byte_in[5:0];
            end
            else if (cmd.px_count && cmd.from_run)
            begin
                run_cnt_reg <= run_cnt_reg - 6'd1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg   <= cmd.kind;
            out_pixel_reg  <= '0;
            out_err_reg    <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_bpp_reg    <= '0;
            out_planes_reg <= '0;
            out_lb_reg     <= '0;
            out_done_reg   <= 1'b0;
            out_last_reg   <= 1'b1;
            unique case (cmd.kind)
                pcxrle_pkg::KIND_PIXEL:
                begin
                    out_pixel_reg <= cmd.from_run ? run_val_reg : byte_in;
                    out_done_reg  <= img_last;
                    out_last_reg  <= !cmd.from_run || img_last ||
                                     (run_cnt_reg == 6'd1);
                end
                pcxrle_pkg::KIND_HDR_OK:
                begin
                    out_x_reg      <= x_end_reg;
                    out_y_reg      <= y_end_reg;
                    out_bpp_reg    <= bpp_reg;
                    out_planes_reg <= planes_reg;
                    out_lb_reg     <= line_bytes_reg;
                end
                pcxrle_pkg::KIND_HDR_ERR:
                begin
                    out_err_reg <= err_code;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_done_reg, out_lb_reg, out_planes_reg, out_bpp_reg,
                       out_y_reg, out_x_reg, out_err_reg, out_pixel_reg};

    `PCX_ASSERT_IMP(a_done_is_last, out_valid_reg && out_done_reg, out_last_reg, "image end not last")
    `PCX_ASSERT_NXT(a_hdr_wrap, cmd.hdr_finish, pos_reg == 7'd0, "header position not cleared")
    `PCX_ASSERT_IMP(a_emit_room, cmd.emit, out_free, "result loaded over a waiting one")

endmodule

/* rtl/core/pcxrle_ctrl.sv */
`include "assert_macros.svh"

module pcxrle_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   first,
    input  pcxrle_pkg::dp_status_t status,
    output pcxrle_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_HEADER = 5'b00001,
        ST_DATA   = 5'b00010,
        ST_VALUE  = 5'b00100,
        ST_RUN    = 5'b01000,
        ST_IDLE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   in_header;

    assign s_tready  = status.out_free && (state_reg != ST_RUN);
    assign accept    = s_tvalid && s_tready;
    assign in_header = first || (state_reg == ST_HEADER);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        if (state_reg == ST_RUN)
        begin
            if (status.out_free)
            begin
                cmd.emit     = 1'b1;
                cmd.kind     = pcxrle_pkg::KIND_PIXEL;
                cmd.from_run = 1'b1;
                cmd.px_count = 1'b1;
                priority if (status.img_last)
                    state_next = ST_IDLE;
                else if (status.run_one)
                    state_next = ST_DATA;
                else
                    state_next = ST_RUN;
            end
        end
        else if (accept)
        begin
            priority if (in_header)
            begin
                if (status.fail)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = pcxrle_pkg::KIND_HDR_ERR;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.hdr_step = 1'b1;
                    if (status.pos_last)
                    begin
                        cmd.emit       = 1'b1;
                        cmd.kind       = pcxrle_pkg::KIND_HDR_OK;
                        cmd.hdr_finish = 1'b1;
                        state_next     = ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_HEADER;
                    end
                end
            end
            else if (state_reg == ST_DATA)
            begin
                if (status.marker)
                begin
                    cmd.run_cnt_load = 1'b1;
                    state_next       = ST_VALUE;
                end
                else
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = pcxrle_pkg::KIND_PIXEL;
                    cmd.px_count = 1'b1;
                    state_next   = status.img_last ? ST_IDLE : ST_DATA;
                end
            end
            else if (state_reg == ST_VALUE)
            begin
                cmd.run_val_load = 1'b1;
                state_next       = status.cnt_zero ? ST_DATA : ST_RUN;
            end
            else
            begin
                state_next = state_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PCX_ASSERT_NXT(a_err_idle, accept && in_header && status.fail, state_reg == ST_IDLE, "no idle after header error")
    `PCX_ASSERT_IMP(a_run_stall, state_reg == ST_RUN, !s_tready && !cmd.hdr_step, "byte taken during run")
    `PCX_ASSERT_IMP(a_single_src, cmd.emit && !cmd.from_run, accept, "result without a byte")

endmodule

/* rtl/core/pcx_header_check_and_rle_decode.sv */
// Channel   Dir  tdata (low bit up)                               tuser        tlast
// s_axis    in   byte_in[7:0]                                     first        -
// m_axis    out  pixel, error_code, x_end, y_end, bits_per_pixel, result_kind  last
//                plane_count, line_bytes, image_done
//
// Header bytes are checked and captured as taken; a literal data byte leaves as
// one pixel. A run marker and its value byte load the run count and value, then
// the run's pixels leave at one per cycle from the run state while the output
// register is free, with the input held; the image limit can cut a run short.
// The single output register sets the pace: a byte is taken only when it is empty
// or being emptied. rst_n clears the controller, header position and counters.
// A stall on m_axis holds the output register and, through it, the input side.
module pcx_header_check_and_rle_decode
(
    input  logic                            clk,
    input  logic                            rst_n,
    // byte_in[7:0]
    input  logic [7:0]                      s_axis_tdata,
    // first
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pixel[7:0], error_code[10:8], x_end[26:11], y_end[42:27],
    // bits_per_pixel[46:43], plane_count[54:47], line_bytes[70:55], image_done[71]
    output logic [pcxrle_pkg::TDATA_W-1:0]  m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready
);

    pcxrle_pkg::dp_cmd_t    cmd;
    pcxrle_pkg::dp_status_t status;

    // controller: header, data, run-value, run and idle phases
    pcxrle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .first    (s_axis_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: header checks and capture, pixel limit, run state, output register
    pcxrle_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (s_axis_tdata),
        .first    (s_axis_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule
